@@ rtl/bmcc_pkg.sv @@
// shared types, constants and helper functions of the convergence count unit
// used by the multiplier, the divider and the top level sequencer
package bmcc_pkg;

    localparam int QW = 48;

    localparam logic [63:0] E9  = 64'd1000000000;
    localparam logic [63:0] E18 = 64'd1000000000000000000;

    localparam logic signed [QW-1:0] QMAX = {1'b0, {(QW-1){1'b1}}};
    localparam logic signed [QW-1:0] QMIN = {1'b1, {(QW-1){1'b0}}};
    localparam logic [63:0] LIM48 = 64'h0001_0000_0000_0000;

    // decimal constant (whole part, 18 fraction digits) to q16.32, rounded half up
    function automatic logic [QW-1:0] make_const(input logic [63:0] whole,
                                                 input logic [63:0] frac);
        logic [63:0] fh;
        logic [63:0] fl;
        logic [63:0] t;
        logic [63:0] q1;
        logic [63:0] r1;
        logic [63:0] s;
        logic [63:0] f;
        logic [63:0] v;
        fh = frac / E9;
        fl = frac % E9;
        t  = fh << 32;
        q1 = t / E9;
        r1 = t % E9;
        s  = r1 * E9 + (fl << 32);
        f  = q1 + (s + E18 / 64'd2) / E18;
        v  = (whole << 32) + f;
        return v[QW-1:0];
    endfunction

    localparam logic [QW-1:0] K_A1  = make_const(64'd0,  64'd434791674400534484);
    localparam logic [QW-1:0] K_A2  = make_const(64'd0,  64'd565208325599465515);
    localparam logic [QW-1:0] K_B1  = make_const(64'd0,  64'd246846263944619125);
    localparam logic [QW-1:0] K_B2  = make_const(64'd0,  64'd753153736055380874);
    localparam logic [QW-1:0] K_C1  = make_const(64'd26, 64'd982266348563755135);
    localparam logic [QW-1:0] K_C2  = make_const(64'd4,  64'd128561677155244781);
    localparam logic [QW-1:0] K_C3  = make_const(64'd21, 64'd853704671408510353);
    localparam logic [QW-1:0] K_D1  = make_const(64'd2,  64'd313393412192523856);
    localparam logic [QW-1:0] K_D2  = make_const(64'd1,  64'd313393412192523856);
    localparam logic [QW-1:0] K_E1  = make_const(64'd1,  64'd413535481316514897);
    localparam logic [QW-1:0] K_E2  = make_const(64'd0,  64'd37061379021381916);
    localparam logic [QW-1:0] K_E3  = make_const(64'd0,  64'd450596860337896814);
    localparam logic [QW-1:0] K_F1  = make_const(64'd3,  64'd7300493416631077);
    localparam logic [QW-1:0] K_F2  = make_const(64'd4,  64'd7300493416631077);
    localparam logic [QW-1:0] K_FPX = make_const(64'd1,  64'd460092553582583482);
    localparam logic [QW-1:0] K_FPY_MAG = make_const(64'd5, 64'd381069687747360218);
    localparam logic [QW-1:0] K_FPY = QW'(48'd0 - K_FPY_MAG);
    localparam logic [QW-1:0] K_ONE = QW'(64'h1_0000_0000);

    function automatic logic signed [QW-1:0] kconst(input logic [3:0] idx);
        logic [QW-1:0] v;
        unique case (idx)
            4'd0:    v = K_A1;
            4'd1:    v = K_A2;
            4'd2:    v = K_B1;
            4'd3:    v = K_B2;
            4'd4:    v = K_C1;
            4'd5:    v = K_C2;
            4'd6:    v = K_C3;
            4'd7:    v = K_D1;
            4'd8:    v = K_D2;
            4'd9:    v = K_E1;
            4'd10:   v = K_E2;
            4'd11:   v = K_E3;
            4'd12:   v = K_F1;
            4'd13:   v = K_F2;
            4'd14:   v = K_FPX;
            default: v = K_FPY;
        endcase
        return $signed(v);
    endfunction

    // sign and magnitude back to q16.32 with saturation
    function automatic logic signed [QW-1:0] sat_mag(input logic neg, input logic [63:0] mag);
        logic [QW-1:0] v;
        if (neg) begin
            if (mag > {16'd0, 1'b1, 47'd0}) begin
                v = QMIN;
            end
            else begin
                v = QW'(48'd0 - mag[QW-1:0]);
            end
        end
        else begin
            if (mag > {16'd0, QMAX}) begin
                v = QMAX;
            end
            else begin
                v = mag[QW-1:0];
            end
        end
        return $signed(v);
    endfunction

    // micro-operations
    localparam logic [2:0] OP_MUL = 3'd0;
    localparam logic [2:0] OP_DIV = 3'd1;
    localparam logic [2:0] OP_ADD = 3'd2;
    localparam logic [2:0] OP_SUB = 3'd3;
    localparam logic [2:0] OP_CHK = 3'd4;

    // working registers
    localparam logic [3:0] REG_X  = 4'd0;
    localparam logic [3:0] REG_Y  = 4'd1;
    localparam logic [3:0] REG_X0 = 4'd2;
    localparam logic [3:0] REG_Y0 = 4'd3;
    localparam logic [3:0] REG_T0 = 4'd4;
    localparam logic [3:0] REG_T1 = 4'd5;
    localparam logic [3:0] REG_T2 = 4'd6;
    localparam logic [3:0] REG_T3 = 4'd7;
    localparam logic [3:0] REG_T4 = 4'd8;

    // operand sources: registers, one, or a map constant when bit 4 is set
    localparam logic [4:0] SRC_X   = 5'd0;
    localparam logic [4:0] SRC_Y   = 5'd1;
    localparam logic [4:0] SRC_T0  = 5'd4;
    localparam logic [4:0] SRC_T1  = 5'd5;
    localparam logic [4:0] SRC_T2  = 5'd6;
    localparam logic [4:0] SRC_T3  = 5'd7;
    localparam logic [4:0] SRC_T4  = 5'd8;
    localparam logic [4:0] SRC_ONE = 5'd9;
    localparam logic [4:0] SRC_K0  = 5'd16;
    localparam logic [4:0] SRC_K1  = 5'd17;
    localparam logic [4:0] SRC_K2  = 5'd18;
    localparam logic [4:0] SRC_K3  = 5'd19;
    localparam logic [4:0] SRC_K4  = 5'd20;
    localparam logic [4:0] SRC_K5  = 5'd21;
    localparam logic [4:0] SRC_K6  = 5'd22;
    localparam logic [4:0] SRC_K7  = 5'd23;
    localparam logic [4:0] SRC_K8  = 5'd24;
    localparam logic [4:0] SRC_K9  = 5'd25;
    localparam logic [4:0] SRC_K10 = 5'd26;
    localparam logic [4:0] SRC_K11 = 5'd27;
    localparam logic [4:0] SRC_K12 = 5'd28;
    localparam logic [4:0] SRC_K13 = 5'd29;
    localparam logic [4:0] SRC_K14 = 5'd30;
    localparam logic [4:0] SRC_K15 = 5'd31;

    typedef struct packed {
        logic [2:0] op;
        logic [4:0] srca;
        logic [4:0] srcb;
        logic [3:0] dst;
    } uop_t;

    localparam logic [5:0] PC_FWD = 6'd0;
    localparam logic [5:0] PC_INV = 6'd20;

    function automatic uop_t uop_rom(input logic [5:0] pc);
        uop_t u;
        unique case (pc)
            // forward map
            6'd0:  u = '{OP_MUL, SRC_X,   SRC_Y,   REG_T0};
            6'd1:  u = '{OP_MUL, SRC_K0,  SRC_X,   REG_T1};
            6'd2:  u = '{OP_MUL, SRC_K1,  SRC_T0,  REG_T2};
            6'd3:  u = '{OP_ADD, SRC_T1,  SRC_T2,  REG_T1};
            6'd4:  u = '{OP_MUL, SRC_K2,  SRC_X,   REG_T2};
            6'd5:  u = '{OP_MUL, SRC_K3,  SRC_T0,  REG_T3};
            6'd6:  u = '{OP_ADD, SRC_T2,  SRC_T3,  REG_T2};
            6'd7:  u = '{OP_MUL, SRC_K4,  SRC_Y,   REG_T3};
            6'd8:  u = '{OP_MUL, SRC_K5,  SRC_X,   REG_T4};
            6'd9:  u = '{OP_SUB, SRC_T3,  SRC_T4,  REG_T3};
            6'd10: u = '{OP_MUL, SRC_K6,  SRC_T0,  REG_T4};
            6'd11: u = '{OP_SUB, SRC_T3,  SRC_T4,  REG_T3};
            6'd12: u = '{OP_DIV, SRC_T3,  SRC_T1,  REG_Y};
            6'd13: u = '{OP_DIV, SRC_T2,  SRC_T1,  REG_X};
            6'd14: u = '{OP_SUB, SRC_X,   SRC_K14, REG_T0};
            6'd15: u = '{OP_SUB, SRC_Y,   SRC_K15, REG_T1};
            6'd16: u = '{OP_MUL, SRC_T0,  SRC_T0,  REG_T0};
            6'd17: u = '{OP_MUL, SRC_T1,  SRC_T1,  REG_T1};
            6'd18: u = '{OP_ADD, SRC_T0,  SRC_T1,  REG_T0};
            6'd19: u = '{OP_CHK, SRC_T0,  SRC_T0,  REG_T0};
            // inverse map
            6'd20: u = '{OP_MUL, SRC_K7,  SRC_X,   REG_T0};
            6'd21: u = '{OP_SUB, SRC_T0,  SRC_K8,  REG_T0};
            6'd22: u = '{OP_MUL, SRC_K9,  SRC_X,   REG_T1};
            6'd23: u = '{OP_MUL, SRC_K10, SRC_Y,   REG_T2};
            6'd24: u = '{OP_ADD, SRC_T1,  SRC_T2,  REG_T1};
            6'd25: u = '{OP_SUB, SRC_T1,  SRC_K11, REG_T1};
            6'd26: u = '{OP_MUL, SRC_K12, SRC_X,   REG_T2};
            6'd27: u = '{OP_SUB, SRC_K13, SRC_T2,  REG_T2};
            6'd28: u = '{OP_DIV, SRC_T0,  SRC_T1,  REG_X};
            6'd29: u = '{OP_DIV, SRC_T0,  SRC_T2,  REG_Y};
            6'd30: u = '{OP_SUB, SRC_X,   SRC_ONE, REG_T0};
            6'd31: u = '{OP_SUB, SRC_Y,   SRC_ONE, REG_T1};
            6'd32: u = '{OP_MUL, SRC_T0,  SRC_T0,  REG_T0};
            6'd33: u = '{OP_MUL, SRC_T1,  SRC_T1,  REG_T1};
            6'd34: u = '{OP_ADD, SRC_T0,  SRC_T1,  REG_T0};
            default: u = '{OP_CHK, SRC_T0, SRC_T0, REG_T0};
        endcase
        return u;
    endfunction

endpackage

@@ rtl/bmcc_mul.sv @@
// q16.32 saturating multiplier, one 32x32 partial product per cycle
// depends on bmcc_pkg
module bmcc_mul
    import bmcc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic signed [QW-1:0] a,
    input  logic signed [QW-1:0] b,
    output logic                 done,
    output logic signed [QW-1:0] p
);

    logic            busy_reg, busy_next;
    logic [2:0]      cnt_reg, cnt_next;
    logic [QW-1:0]   ua_reg, ua_next;
    logic [QW-1:0]   ub_reg, ub_next;
    logic            neg_reg, neg_next;
    logic [63:0]     prod_reg, prod_next;
    logic [63:0]     acc_reg, acc_next;
    logic            over_reg, over_next;
    logic [QW-1:0]   p_reg, p_next;
    logic            done_reg, done_next;
    logic [31:0]     mul_a;
    logic [31:0]     mul_b;

    // partial product select: hi*hi, hi*lo, lo*hi, lo*lo
    always_comb
    begin
        unique case (cnt_reg[1:0])
            2'd0:
            begin
                mul_a = {16'd0, ua_reg[47:32]};
                mul_b = {16'd0, ub_reg[47:32]};
            end
            2'd1:
            begin
                mul_a = {16'd0, ua_reg[47:32]};
                mul_b = ub_reg[31:0];
            end
            2'd2:
            begin
                mul_a = ua_reg[31:0];
                mul_b = {16'd0, ub_reg[47:32]};
            end
            default:
            begin
                mul_a = ua_reg[31:0];
                mul_b = ub_reg[31:0];
            end
        endcase
    end

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        ua_next   = ua_reg;
        ub_next   = ub_reg;
        neg_next  = neg_reg;
        prod_next = prod_reg;
        acc_next  = acc_reg;
        over_next = over_reg;
        p_next    = p_reg;
        done_next = 1'b0;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = 3'd0;
            ua_next   = a[QW-1] ? QW'(48'd0 - a) : a;
            ub_next   = b[QW-1] ? QW'(48'd0 - b) : b;
            neg_next  = a[QW-1] ^ b[QW-1];
            acc_next  = 64'd0;
            over_next = 1'b0;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + 3'd1;
            if (cnt_reg <= 3'd3)
            begin
                prod_next = 64'(mul_a * mul_b);
            end
            unique case (cnt_reg)
                3'd1:
                begin
                    over_next = (prod_reg >= 64'h1_0000);
                    acc_next  = {prod_reg[31:0], 32'd0};
                end
                3'd2, 3'd3: acc_next = acc_reg + prod_reg;
                3'd4:       acc_next = acc_reg + {32'd0, prod_reg[63:32]};
                3'd5:
                begin
                    p_next    = sat_mag(neg_reg, over_reg ? LIM48 : acc_reg);
                    done_next = 1'b1;
                    busy_next = 1'b0;
                end
                default: acc_next = acc_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= 3'd0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ua_reg   <= ua_next;
        ub_reg   <= ub_next;
        neg_reg  <= neg_next;
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        over_reg <= over_next;
        p_reg    <= p_next;
    end

    assign done = done_reg;
    assign p    = $signed(p_reg);

endmodule

@@ rtl/bmcc_div.sv @@
// q16.32 saturating divider, restoring, one quotient bit per cycle (80 steps)
// depends on bmcc_pkg
module bmcc_div
    import bmcc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic signed [QW-1:0] n,
    input  logic signed [QW-1:0] d,
    output logic                 done,
    output logic signed [QW-1:0] p
);

    localparam logic [6:0] LAST_STEP = 7'd79;

    logic            busy_reg, busy_next;
    logic [6:0]      step_reg, step_next;
    logic [QW-1:0]   un_reg, un_next;
    logic [QW-1:0]   ud_reg, ud_next;
    logic [QW-1:0]   r_reg, r_next;
    logic [QW-1:0]   q_reg, q_next;
    logic            over_reg, over_next;
    logic            neg_reg, neg_next;
    logic [QW-1:0]   p_reg, p_next;
    logic            done_reg, done_next;
    logic [QW:0]     rs;
    logic            qb;

    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        un_next   = un_reg;
        ud_next   = ud_reg;
        r_next    = r_reg;
        q_next    = q_reg;
        over_next = over_reg;
        neg_next  = neg_reg;
        p_next    = p_reg;
        done_next = 1'b0;
        // dividend bits come out of the top, zeros follow for the fraction
        rs        = {r_reg, un_reg[QW-1]};
        qb        = (rs >= {1'b0, ud_reg});
        if (start)
        begin
            if (d == '0)
            begin
                p_next    = n[QW-1] ? QMIN : QMAX;
                done_next = 1'b1;
            end
            else
            begin
                busy_next = 1'b1;
                step_next = 7'd0;
                un_next   = n[QW-1] ? QW'(48'd0 - n) : n;
                ud_next   = d[QW-1] ? QW'(48'd0 - d) : d;
                neg_next  = n[QW-1] ^ d[QW-1];
                r_next    = '0;
                q_next    = '0;
                over_next = 1'b0;
            end
        end
        else if (busy_reg)
        begin
            un_next = {un_reg[QW-2:0], 1'b0};
            r_next  = qb ? QW'(rs - {1'b0, ud_reg}) : rs[QW-1:0];
            if (!over_reg)
            begin
                if (q_reg[QW-1])
                begin
                    over_next = 1'b1;
                end
                else
                begin
                    q_next = {q_reg[QW-2:0], qb};
                end
            end
            step_next = step_reg + 7'd1;
            if (step_reg == LAST_STEP)
            begin
                p_next    = sat_mag(neg_reg, over_next ? LIM48 : {16'd0, q_next});
                done_next = 1'b1;
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= 7'd0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        un_reg   <= un_next;
        ud_reg   <= ud_next;
        r_reg    <= r_next;
        q_reg    <= q_next;
        over_reg <= over_next;
        neg_reg  <= neg_next;
        p_reg    <= p_next;
    end

    assign done = done_reg;
    assign p    = $signed(p_reg);

endmodule

@@ rtl/birational_map_convergence_count_unit.sv @@
// Counts how many forward map steps and inverse map steps a start point takes to come
// within the threshold of the fixed point; one word in, one count word out. Items are
// processed one at a time: in_stall stays high from the accepted word until its count
// has been moved into the output register. A map step runs as a micro-program on one
// shared multiplier (four 32x32 partial products per product) and one restoring divider
// (one bit a cycle).
// Depends on bmcc_pkg.
module birational_map_convergence_count_unit
    import bmcc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic signed [47:0]   start_x,
    input  logic signed [47:0]   start_y,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [12:0]          count_code,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic                 cfg_index,
    input  logic [31:0]          cfg_data
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_HEAD = 3'd1;
    localparam logic [2:0] ST_EXEC = 3'd2;
    localparam logic [2:0] ST_WAIT = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    localparam logic CFG_MAX_ITER  = 1'b0;
    localparam logic CFG_THRESHOLD = 1'b1;

    logic [2:0]  state_reg, state_next;
    logic [7:0]  max_iter_reg, max_iter_next;
    logic [31:0] thr_reg, thr_next;
    logic [5:0]  pc_reg, pc_next;
    logic [7:0]  cnt_reg, cnt_next;
    logic [7:0]  icnt_reg, icnt_next;
    logic        phase_reg, phase_next;
    logic [12:0] res_reg, res_next;
    logic        out_valid_reg, out_valid_next;

    logic signed [QW-1:0] x_reg, x_next;
    logic signed [QW-1:0] y_reg, y_next;
    logic signed [QW-1:0] x0_reg, x0_next;
    logic signed [QW-1:0] y0_reg, y0_next;
    logic signed [QW-1:0] t0_reg, t0_next;
    logic signed [QW-1:0] t1_reg, t1_next;
    logic signed [QW-1:0] t2_reg, t2_next;
    logic signed [QW-1:0] t3_reg, t3_next;
    logic signed [QW-1:0] t4_reg, t4_next;

    uop_t                 uop;
    logic signed [QW-1:0] opa;
    logic signed [QW-1:0] opb;
    logic signed [QW:0]   alu_wide;
    logic signed [QW-1:0] alu_res;
    logic signed [QW-1:0] wb_data;
    logic                 mul_start;
    logic                 div_start;
    logic                 mul_done;
    logic                 div_done;
    logic signed [QW-1:0] mul_p;
    logic signed [QW-1:0] div_p;
    logic signed [53:0]   y20;
    logic signed [QW-1:0] y20_sat;
    logic                 near;
    logic                 wr_en;
    logic                 phase_end;

    function automatic logic signed [QW-1:0] src_val(input logic [4:0] code);
        logic signed [QW-1:0] v;
        if (code[4])
        begin
            v = kconst(code[3:0]);
        end
        else
        begin
            unique case (code[3:0])
                REG_X:   v = x_reg;
                REG_Y:   v = y_reg;
                REG_X0:  v = x0_reg;
                REG_Y0:  v = y0_reg;
                REG_T0:  v = t0_reg;
                REG_T1:  v = t1_reg;
                REG_T2:  v = t2_reg;
                REG_T3:  v = t3_reg;
                REG_T4:  v = t4_reg;
                default: v = $signed(K_ONE);
            endcase
        end
        return v;
    endfunction

    assign uop = uop_rom(pc_reg);
    assign opa = src_val(uop.srca);
    assign opb = src_val(uop.srcb);

    // saturating add or subtract
    always_comb
    begin
        if (uop.op == OP_SUB)
        begin
            alu_wide = {opa[QW-1], opa} - {opb[QW-1], opb};
        end
        else
        begin
            alu_wide = {opa[QW-1], opa} + {opb[QW-1], opb};
        end
        if (alu_wide[QW] != alu_wide[QW-1])
        begin
            alu_res = alu_wide[QW] ? QMIN : QMAX;
        end
        else
        begin
            alu_res = alu_wide[QW-1:0];
        end
    end

    // start y times 20 as 16y + 4y, saturated
    always_comb
    begin
        y20 = ($signed({{6{start_y[47]}}, start_y}) <<< 4)
            + ($signed({{6{start_y[47]}}, start_y}) <<< 2);
        if (y20 > 54'(QMAX))
        begin
            y20_sat = QMAX;
        end
        else if (y20 < $signed({{6{1'b1}}, QMIN}))
        begin
            y20_sat = QMIN;
        end
        else
        begin
            y20_sat = y20[QW-1:0];
        end
    end

    assign near    = ($unsigned(t0_reg) < {16'd0, thr_reg});
    assign wb_data = (uop.op == OP_DIV) ? div_p : mul_p;

    always_comb
    begin
        state_next     = state_reg;
        max_iter_next  = max_iter_reg;
        thr_next       = thr_reg;
        pc_next        = pc_reg;
        cnt_next       = cnt_reg;
        icnt_next      = icnt_reg;
        phase_next     = phase_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        x_next  = x_reg;
        y_next  = y_reg;
        x0_next = x0_reg;
        y0_next = y0_reg;
        t0_next = t0_reg;
        t1_next = t1_reg;
        t2_next = t2_reg;
        t3_next = t3_reg;
        t4_next = t4_reg;
        mul_start = 1'b0;
        div_start = 1'b0;
        wr_en     = 1'b0;
        phase_end = 1'b0;

        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_MAX_ITER:  max_iter_next = cfg_data[7:0];
                CFG_THRESHOLD: thr_next      = cfg_data;
                default:       thr_next      = thr_reg;
            endcase
        end

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    x_next     = start_x;
                    x0_next    = start_x;
                    y_next     = y20_sat;
                    y0_next    = y20_sat;
                    cnt_next   = 8'd0;
                    phase_next = 1'b0;
                    pc_next    = PC_FWD;
                    state_next = ST_HEAD;
                end
            end
            ST_HEAD:
            begin
                if (cnt_reg == max_iter_reg)
                begin
                    phase_end = 1'b1;
                end
                else
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                unique case (uop.op)
                    OP_MUL:
                    begin
                        mul_start  = 1'b1;
                        state_next = ST_WAIT;
                    end
                    OP_DIV:
                    begin
                        div_start  = 1'b1;
                        state_next = ST_WAIT;
                    end
                    OP_ADD, OP_SUB:
                    begin
                        wr_en   = 1'b1;
                        pc_next = pc_reg + 6'd1;
                    end
                    default:
                    begin
                        if (near)
                        begin
                            phase_end = 1'b1;
                        end
                        else
                        begin
                            cnt_next   = cnt_reg + 8'd1;
                            pc_next    = phase_reg ? PC_INV : PC_FWD;
                            state_next = ST_HEAD;
                        end
                    end
                endcase
            end
            ST_WAIT:
            begin
                if (mul_done || div_done)
                begin
                    wr_en      = 1'b1;
                    pc_next    = pc_reg + 6'd1;
                    state_next = ST_EXEC;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // phase one hands over to phase two, phase two finishes the item
        if (phase_end)
        begin
            if (!phase_reg)
            begin
                icnt_next  = cnt_reg;
                x_next     = x0_reg;
                y_next     = y0_reg;
                cnt_next   = 8'd0;
                phase_next = 1'b1;
                pc_next    = PC_INV;
                state_next = ST_HEAD;
            end
            else
            begin
                res_next   = {1'b0, icnt_reg, 4'd0} + {5'd0, cnt_reg};
                state_next = ST_DONE;
            end
        end

        if (wr_en)
        begin
            unique case (uop.dst)
                REG_X:   x_next  = (state_reg == ST_WAIT) ? wb_data : alu_res;
                REG_Y:   y_next  = (state_reg == ST_WAIT) ? wb_data : alu_res;
                REG_T0:  t0_next = (state_reg == ST_WAIT) ? wb_data : alu_res;
                REG_T1:  t1_next = (state_reg == ST_WAIT) ? wb_data : alu_res;
                REG_T2:  t2_next = (state_reg == ST_WAIT) ? wb_data : alu_res;
                REG_T3:  t3_next = (state_reg == ST_WAIT) ? wb_data : alu_res;
                default: t4_next = (state_reg == ST_WAIT) ? wb_data : alu_res;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            max_iter_reg  <= 8'd100;
            thr_reg       <= 32'd42949673;
            pc_reg        <= PC_FWD;
            cnt_reg       <= 8'd0;
            icnt_reg      <= 8'd0;
            phase_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            max_iter_reg  <= max_iter_next;
            thr_reg       <= thr_next;
            pc_reg        <= pc_next;
            cnt_reg       <= cnt_next;
            icnt_reg      <= icnt_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
        x0_reg  <= x0_next;
        y0_reg  <= y0_next;
        t0_reg  <= t0_next;
        t1_reg  <= t1_next;
        t2_reg  <= t2_next;
        t3_reg  <= t3_next;
        t4_reg  <= t4_next;
    end

    // count word register, loaded when the item finishes
    logic [12:0] code_reg;
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_DONE && (!out_valid_reg || !out_stall))
        begin
            code_reg <= res_reg;
        end
    end

    bmcc_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (opa),
        .b     (opb),
        .done  (mul_done),
        .p     (mul_p)
    );

    bmcc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .n     (opa),
        .d     (opb),
        .done  (div_done),
        .p     (div_p)
    );

    assign in_stall   = (state_reg != ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign count_code = code_reg;
    assign cfg_ready  = 1'b1;

`ifndef SYNTH
    a_one_unit: assert property (@(posedge clk) disable iff (!rst_n)
        !(mul_start && div_start))
        else $error("multiplier and divider started together");

    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (mul_done || div_done) |-> (state_reg == ST_WAIT))
        else $error("arithmetic unit finished outside a wait");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EXEC || state_reg == ST_WAIT) |-> (cnt_reg < max_iter_reg))
        else $error("iteration count ran past the limit");

    a_start_leaves: assert property (@(posedge clk) disable iff (!rst_n)
        (mul_start || div_start) |=> (state_reg == ST_WAIT))
        else $error("sequencer did not wait on a started unit");
`endif

endmodule

@@ bench/birational_map_convergence_count_unit_tb.sv @@
// testbench for birational_map_convergence_count_unit: drives start points, predicts each
// count word from a q16.32 model of both map phases and checks it; depends on bmcc_pkg
module birational_map_convergence_count_unit_tb;
    import bmcc_pkg::*;

    typedef logic signed [47:0] q_t;

    localparam bit CFG_MAX_ITER = 1'b0;
    localparam bit CFG_NEAR_SQ  = 1'b1;
    localparam int CYCLE_LIMIT  = 6000000;
    localparam int DRAIN_CYCLES = 60;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    q_t          start_x = '0;
    q_t          start_y = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [12:0] count_code;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = 1'b0;
    logic [31:0] cfg_data = '0;

    logic [7:0]  max_iter_cfg = 8'd100;
    logic [31:0] near_sq_cfg = 32'd42949673;
    logic [12:0] pending_counts[$];
    int          errors = 0;
    int          words_sent = 0;
    int          words_checked = 0;
    int          cycles = 0;
    bit          no_gaps = 1'b0;

    birational_map_convergence_count_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .start_x    (start_x),
        .start_y    (start_y),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .count_code (count_code),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always #2 clk = ~clk;

    // ---------------- fixed point arithmetic ----------------
    function automatic q_t clamp48(input longint v);
        if (v > longint'(QMAX))
            return QMAX;
        if (v < longint'(QMIN))
            return QMIN;
        return q_t'(v);
    endfunction

    function automatic q_t signed_mag(input bit neg, input logic [127:0] mag);
        if (neg)
        begin
            if (mag > 128'h8000_0000_0000)
                return QMIN;
            return q_t'(-longint'(mag[63:0]));
        end
        if (mag > 128'h7FFF_FFFF_FFFF)
            return QMAX;
        return q_t'(mag[63:0]);
    endfunction

    function automatic logic [127:0] abs128(input q_t v);
        longint w;
        w = v;
        return (w < 0) ? 128'(-w) : 128'(w);
    endfunction

    function automatic q_t fx_mul(input q_t a, input q_t b);
        logic [127:0] p;
        p = abs128(a) * abs128(b);
        return signed_mag((a < 0) != (b < 0), p >> 32);
    endfunction

    function automatic q_t fx_div(input q_t n, input q_t d);
        logic [127:0] quo;
        if (d == 0)
            return (n < 0) ? QMIN : QMAX;
        quo = (abs128(n) << 32) / abs128(d);
        return signed_mag((n < 0) != (d < 0), quo);
    endfunction

    function automatic q_t fx_add(input q_t a, input q_t b);
        return clamp48(longint'(a) + longint'(b));
    endfunction

    function automatic q_t fx_sub(input q_t a, input q_t b);
        return clamp48(longint'(a) - longint'(b));
    endfunction

    function automatic bit is_near(input q_t x, input q_t y, input q_t px, input q_t py);
        q_t dx;
        q_t dy;
        q_t d2;
        dx = fx_sub(x, px);
        dy = fx_sub(y, py);
        d2 = fx_add(fx_mul(dx, dx), fx_mul(dy, dy));
        return longint'(d2) < longint'({32'd0, near_sq_cfg});
    endfunction

    function automatic logic [12:0] convergence_code(input q_t sx, input q_t sy);
        q_t x;
        q_t y;
        q_t y0;
        q_t xy;
        q_t den;
        q_t num;
        q_t ny;
        q_t nn;
        q_t dxn;
        q_t dyn;
        q_t one;
        int fwd;
        int inv;
        one = q_t'(64'h1_0000_0000);
        y0 = clamp48(longint'(sy) * 20);
        x = sx;
        y = y0;
        for (fwd = 0; fwd < max_iter_cfg; fwd++)
        begin
            xy  = fx_mul(x, y);
            den = fx_add(fx_mul(K_A1, x), fx_mul(K_A2, xy));
            num = fx_add(fx_mul(K_B1, x), fx_mul(K_B2, xy));
            ny  = fx_sub(fx_sub(fx_mul(K_C1, y), fx_mul(K_C2, x)), fx_mul(K_C3, xy));
            y = fx_div(ny, den);
            x = fx_div(num, den);
            if (is_near(x, y, K_FPX, K_FPY))
                break;
        end
        x = sx;
        y = y0;
        for (inv = 0; inv < max_iter_cfg; inv++)
        begin
            nn  = fx_sub(fx_mul(K_D1, x), K_D2);
            dxn = fx_sub(fx_add(fx_mul(K_E1, x), fx_mul(K_E2, y)), K_E3);
            dyn = fx_sub(K_F2, fx_mul(K_F1, x));
            y = fx_div(nn, dyn);
            x = fx_div(nn, dxn);
            if (is_near(x, y, one, one))
                break;
        end
        return 13'(fwd * 16 + inv);
    endfunction

    // ---------------- drivers ----------------
    task automatic send_point(input q_t sx, input q_t sy);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 13);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        start_x  <= sx;
        start_y  <= sy;
        pending_counts.push_back(convergence_code(sx, sy));
        words_sent++;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // lets every outstanding count come back before the block is touched again
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_counts.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input bit idx, input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_MAX_ITER)
            max_iter_cfg = value[7:0];
        else
            near_sq_cfg = value;
        @(posedge clk);
    endtask

    task automatic set_config(input logic [7:0] iters, input logic [31:0] near_sq);
        wait_drained();
        write_reg(CFG_MAX_ITER, {24'd0, iters});
        write_reg(CFG_NEAR_SQ, near_sq);
    endtask

    function automatic q_t rand_q();
        case ($urandom_range(0, 3))
            0: return q_t'({$urandom, $urandom});
            1: return q_t'($signed($urandom_range(0, 32'h7FFF_FFFF))) <<< $urandom_range(0, 4);
            2: return (K_FPX + q_t'($signed($urandom) >>> 6));
            default: return q_t'(64'h1_0000_0000) + q_t'($signed($urandom) >>> 4);
        endcase
    endfunction

    // ---------------- result side ----------------
    initial
    begin
        int hold;
        forever
        begin
            hold = no_gaps ? 0 : $urandom_range(0, 13);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        logic [12:0] want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_counts.size() == 0)
            begin
                $display("%0t: count word %0d with nothing expected", $time, count_code);
                errors++;
            end
            else
            begin
                want = pending_counts.pop_front();
                words_checked++;
                if (count_code !== want)
                begin
                    $display("%0t: count_code expected %0d actual %0d", $time, want, count_code);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ---------------- tests ----------------
    task automatic test_reset_values();
        send_point(q_t'(64'h1_0000_0000), q_t'(48'd214748364));
        send_point(K_FPX, q_t'(48'd0) - q_t'(48'd1155579232));
    endtask

    task automatic test_zero_iterations();
        set_config(8'd0, 32'd42949673);
        send_point(QMAX, QMIN);
        send_point(q_t'(0), q_t'(0));
    endtask

    task automatic test_field_extremes();
        set_config(8'd4, 32'd42949673);
        send_point(q_t'(0), q_t'(0));
        send_point(q_t'(0), q_t'(-48'sd5));
        send_point(QMAX, QMAX);
        send_point(QMIN, QMIN);
        send_point(QMAX, QMIN);
        send_point(QMIN, QMAX);
        send_point(q_t'(-48'sd1), q_t'(48'sd1));
        send_point(q_t'(48'h5555_5555_5555), q_t'(48'hAAAA_AAAA_AAAA));
        // near the forward fixed point after scaling
        send_point(K_FPX, q_t'(48'd0) - q_t'(48'd1155579232));
        // scaled y lands just below one, start near the inverse target
        send_point(q_t'(64'h1_0000_0000), q_t'(48'd214748364));
        // divisor of the inverse y step goes to zero
        send_point(fx_div(K_F2, K_F1), q_t'(48'd0));
        send_point(q_t'(48'd1) <<< 40, q_t'(48'd3) <<< 38);
    endtask

    task automatic test_threshold_extremes();
        set_config(8'd3, 32'd0);
        send_point(K_FPX, q_t'(48'd0) - q_t'(48'd1155579232));
        send_point(q_t'(64'h1_0000_0000), q_t'(48'd214748364));
        set_config(8'd255, 32'hFFFF_FFFF);
        send_point(q_t'(64'h1_0000_0000), q_t'(48'd214748364));
        send_point(K_FPX, q_t'(48'd0) - q_t'(48'd1155579232));
    endtask

    task automatic test_random_points();
        logic [31:0] near_sq;
        int phase;
        for (phase = 0; phase < 10; phase++)
        begin
            case ($urandom_range(0, 3))
                0: near_sq = 32'd0;
                1: near_sq = 32'hFFFF_FFFF;
                default: near_sq = $urandom >> $urandom_range(0, 12);
            endcase
            set_config(8'($urandom_range(1, 9)), near_sq);
            no_gaps = (phase % 4 == 3);
            repeat (15) send_point(rand_q(), rand_q());
        end
        no_gaps = 1'b0;
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_values();
        test_zero_iterations();
        test_field_extremes();
        test_threshold_extremes();
        test_random_points();
        wait_drained();
        $display("sent %0d start points, checked %0d count words", words_sent, words_checked);
        $display("covered reset config, zero and full iteration limits, both threshold ends");
        if (errors == 0 && pending_counts.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
